/* rtl/qfan_pkg.sv */
// Shared constants, word types and widths for the quad face area/normal pipeline.
// No dependencies; used by every module under rtl/.
package qfan_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COORD_FRAC_BITS = 16;

    localparam int AREA_W     = 48;
    localparam int NORM_W     = 32;
    localparam int NORM_SHIFT = 30;
    localparam int SPLIT      = 24;
    localparam int SUM_W      = 96;
    localparam int SQ_W       = 98;
    localparam int SQRT_STEPS = 49;
    localparam int DIV_STEPS  = 78;
    localparam int R_W        = AREA_W + 1;
    localparam int Q_W        = 33;
    localparam int OUT_W      = 4 * AREA_W + 3 * NORM_W;

    localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};
    localparam logic [Q_W-1:0]           NORM_ONE = Q_W'(1) << NORM_SHIFT;

    // three area components, x in [0]
    typedef logic [2:0][AREA_W-1:0] t_avec;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        t_avec           av;
    } t_sq_word;

    typedef struct packed {
        logic [AREA_W-1:0]      m;
        logic [2:0][AREA_W-1:0] mag;
        logic [2:0][R_W-1:0]    r;
        logic [2:0][Q_W-1:0]    q;
        t_avec                  av;
    } t_dv_word;

endpackage

/* rtl/quad_face_area_normal.sv */
// Top level: diagonal cross product, sum of squares, root chain, divider chain.
// Depends on qfan_pkg, qfan_sqrt_cell and qfan_div_cell.
//
// Usage: one face (two diagonals, twelve coordinates) enters as one word on the
// slave stream; one word leaves on the master stream with the saturated area
// vector, the face area, the Q2.30 unit normal and, on tuser, the degenerate
// flag (zero area, normal forced to zero).
// Throughput: one face per cycle, sustained, while the receiver keeps up.
// Pipeline: 7 arithmetic stages, 49 square-root cells, one rounding stage,
// 78 divider cells and the output register.
// Stall: the output register has a one-word skid buffer behind it; the whole
// pipe freezes only while that buffer is full, and o_s_axis_tready drops then.
// Reset (synchronous, active low) clears all valid bits; words in flight are
// dropped. The block holds no other state.
module quad_face_area_normal #(
    parameter int COORD_WIDTH = qfan_pkg::COORD_WIDTH_DEF,
    localparam int IN_W = ((12 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // diag1_start_x/y/z, diag1_end_x/y/z, diag2_start_x/y/z, diag2_end_x/y/z
    input  logic [IN_W-1:0]           i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // area_vec_x/y/z, face_area, normal_x/y/z
    output logic [qfan_pkg::OUT_W-1:0] o_m_axis_tdata,
    // degenerate
    output logic [0:0]                o_m_axis_tuser
);
    import qfan_pkg::*;

    localparam int D     = COORD_WIDTH + 1;
    localparam int L     = D / 2;
    localparam int PLO_W = D + L + 1;
    localparam int PHI_W = 2 * D - L;
    localparam int PW    = 2 * D;
    localparam int XW    = (PW + 1 > AREA_W + 2) ? PW + 1 : AREA_W + 2;
    localparam int PA [6] = '{1, 2, 2, 0, 0, 1};
    localparam int PB [6] = '{5, 4, 3, 5, 4, 3};

    logic w_en;
    logic [6:0] r_v;

    logic signed [COORD_WIDTH-1:0] w_c [12];
    logic signed [D-1:0]     r_d    [6];
    logic signed [PLO_W-1:0] r_plo  [6];
    logic signed [PHI_W-1:0] r_phi  [6];
    logic signed [PW-1:0]    r_prod [6];
    t_avec                   w_area;
    t_avec                   r_av4, r_av5, r_av6, r_av7;
    logic [2:0][AREA_W-1:0]  w_mag;
    logic [2:0][2*SPLIT-1:0] r_hh, r_hl, r_ll;
    logic [2:0][SUM_W-1:0]   r_sq;
    logic [SUM_W-1:0]        r_sum;

    t_sq_word w_sq  [SQRT_STEPS+1];
    logic     w_sqv [SQRT_STEPS+1];
    t_dv_word w_dv  [DIV_STEPS+1];
    logic     w_dvv [DIV_STEPS+1];

    logic [SQ_W-1:0] w_root;
    t_dv_word        n_dv0;
    t_dv_word        r_dv0;
    logic            r_dvv0;

    logic [OUT_W-1:0]          w_fin;
    logic                      w_degen;
    logic [2:0][NORM_W-1:0]    w_norm;
    logic [2:0][Q_W-1:0]       w_qr;
    logic [2:0][Q_W-1:0]       w_qc;

    logic               r_out_valid, r_skid_valid;
    logic [OUT_W-1:0]   r_out_data, r_skid_data;
    logic               r_out_user, r_skid_user;
    logic               n_out_valid, n_skid_valid;
    logic [OUT_W-1:0]   n_out_data, n_skid_data;
    logic               n_out_user, n_skid_user;
    logic               w_out_free;
    logic               w_push;

    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en;

    for (genvar k = 0; k < 12; k++) begin : g_unpack
        assign w_c[k] = $signed(i_s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
    end

    // front stages: differences, split products, cross, squares
    for (genvar g = 0; g < 3; g++) begin : g_diff
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d[g]   <= D'(w_c[g+3]) - D'(w_c[g]);
                r_d[g+3] <= D'(w_c[g+9]) - D'(w_c[g+6]);
            end
        end
    end

    for (genvar g = 0; g < 6; g++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_plo[g]  <= PLO_W'(r_d[PA[g]])
                           * PLO_W'($signed({1'b0, r_d[PB[g]][L-1:0]}));
                r_phi[g]  <= PHI_W'(r_d[PA[g]]) * PHI_W'($signed(r_d[PB[g]][D-1:L]));
                r_prod[g] <= (PW'(r_phi[g]) <<< L) + PW'(r_plo[g]);
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_cross
        logic signed [XW-1:0] w_x;
        logic signed [XW-1:0] w_sh;
        always_comb begin
            w_x  = XW'(r_prod[2*c]) - XW'(r_prod[2*c+1])
                 + (XW'(1) <<< COORD_FRAC_BITS);
            w_sh = w_x >>> (COORD_FRAC_BITS + 1);
            if (w_sh > XW'(AREA_MAX)) begin
                w_area[c] = AREA_MAX;
            end else if (w_sh < XW'(AREA_MIN)) begin
                w_area[c] = AREA_MIN;
            end else begin
                w_area[c] = w_sh[AREA_W-1:0];
            end
            w_mag[c] = r_av4[c][AREA_W-1] ? AREA_W'(0) - r_av4[c] : r_av4[c];
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_av4[c] <= w_area[c];
                r_hh[c]  <= w_mag[c][AREA_W-1:SPLIT] * w_mag[c][AREA_W-1:SPLIT];
                r_hl[c]  <= w_mag[c][AREA_W-1:SPLIT] * w_mag[c][SPLIT-1:0];
                r_ll[c]  <= w_mag[c][SPLIT-1:0] * w_mag[c][SPLIT-1:0];
                r_sq[c]  <= (SUM_W'(r_hh[c]) << (2 * SPLIT))
                          + (SUM_W'(r_hl[c]) << (SPLIT + 1)) + SUM_W'(r_ll[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[5:0], i_s_axis_tvalid};
        end
        if (w_en) begin
            r_av5 <= r_av4;
            r_av6 <= r_av5;
            r_av7 <= r_av6;
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    // square-root chain
    assign w_sq[0]  = '{rem: SQ_W'(r_sum), root: '0, av: r_av7};
    assign w_sqv[0] = r_v[6];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        qfan_sqrt_cell #(
            .BIT_POS(2 * (SQRT_STEPS - 1 - g))
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_sqv[g]),
            .i_word (w_sq[g]),
            .o_valid(w_sqv[g+1]),
            .o_word (w_sq[g+1])
        );
    end

    // rounding of the root, divider setup
    always_comb begin
        w_root = w_sq[SQRT_STEPS].root
               + SQ_W'(w_sq[SQRT_STEPS].rem > w_sq[SQRT_STEPS].root);
        n_dv0    = '0;
        n_dv0.m  = w_root[AREA_W-1:0];
        n_dv0.av = w_sq[SQRT_STEPS].av;
        for (int c = 0; c < 3; c++) begin
            n_dv0.mag[c] = w_sq[SQRT_STEPS].av[c][AREA_W-1]
                         ? AREA_W'(0) - w_sq[SQRT_STEPS].av[c] : w_sq[SQRT_STEPS].av[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv0 <= 1'b0;
        end else if (w_en) begin
            r_dvv0 <= w_sqv[SQRT_STEPS];
        end
        if (w_en) begin
            r_dv0 <= n_dv0;
        end
    end

    // divider chain
    assign w_dv[0]  = r_dv0;
    assign w_dvv[0] = r_dvv0;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        qfan_div_cell #(
            .STEP(DIV_STEPS - 1 - g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_dvv[g]),
            .i_word (w_dv[g]),
            .o_valid(w_dvv[g+1]),
            .o_word (w_dv[g+1])
        );
    end

    // final rounding, clamp, sign
    always_comb begin
        w_degen = w_dv[DIV_STEPS].m == '0;
        for (int c = 0; c < 3; c++) begin
            w_qr[c] = w_dv[DIV_STEPS].q[c]
                    + Q_W'({w_dv[DIV_STEPS].r[c], 1'b0} >= (R_W + 1)'(w_dv[DIV_STEPS].m));
            w_qc[c] = (w_qr[c] > NORM_ONE) ? NORM_ONE : w_qr[c];
            if (w_degen) begin
                w_norm[c] = '0;
            end else if (w_dv[DIV_STEPS].av[c][AREA_W-1]) begin
                w_norm[c] = NORM_W'(0) - w_qc[c][NORM_W-1:0];
            end else begin
                w_norm[c] = w_qc[c][NORM_W-1:0];
            end
        end
        w_fin = {w_norm[2], w_norm[1], w_norm[0], w_dv[DIV_STEPS].m,
                 w_dv[DIV_STEPS].av[2], w_dv[DIV_STEPS].av[1], w_dv[DIV_STEPS].av[0]};
    end

    // output register with skid word
    always_comb begin
        w_out_free   = !r_out_valid || i_m_axis_tready;
        w_push       = w_en && w_dvv[DIV_STEPS];
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_skid_data  = r_skid_data;
        n_skid_user  = r_skid_user;
        if (w_push) begin
            if (w_out_free) begin
                n_out_valid = 1'b1;
                n_out_data  = w_fin;
                n_out_user  = w_degen;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = w_fin;
                n_skid_user  = w_degen;
            end
        end
        if (r_skid_valid && w_out_free) begin
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
            n_out_data   = r_skid_data;
            n_out_user   = r_skid_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
        r_skid_data <= n_skid_data;
        r_skid_user <= n_skid_user;
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_user;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user) |->
        (r_out_data[4*AREA_W-1:3*AREA_W] == '0 && r_out_data[OUT_W-1:4*AREA_W] == '0))
        else $error("degenerate face with nonzero area or normal");

    a_area_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_user) |-> r_out_data[4*AREA_W-1:3*AREA_W] != '0)
        else $error("zero face area not flagged degenerate");

    a_norm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |->
        ($signed(r_out_data[4*AREA_W +: NORM_W]) <= $signed(NORM_W'(NORM_ONE))
         && $signed(r_out_data[4*AREA_W +: NORM_W]) >= -$signed(NORM_W'(NORM_ONE))))
        else $error("normal x outside unit range");

endmodule

/* rtl/qfan_sqrt_cell.sv */
// One step of the digit-by-digit square root of the sum of squares.
// Depends on qfan_pkg.
module qfan_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  qfan_pkg::t_sq_word i_word,
    output logic               o_valid,
    output qfan_pkg::t_sq_word o_word
);
    import qfan_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << BIT_POS;

    logic [SQ_W-1:0] w_trial;
    logic            w_ge;
    t_sq_word        n_word;
    t_sq_word        r_word;
    logic            r_valid;

    always_comb begin
        w_trial     = i_word.root + BIT;
        w_ge        = i_word.rem >= w_trial;
        n_word      = i_word;
        n_word.rem  = w_ge ? i_word.rem - w_trial : i_word.rem;
        n_word.root = w_ge ? (i_word.root >> 1) + BIT : i_word.root >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

/* rtl/qfan_div_cell.sv */
// One restoring-division step for all three normal components.
// Depends on qfan_pkg.
module qfan_div_cell #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  qfan_pkg::t_dv_word i_word,
    output logic               o_valid,
    output qfan_pkg::t_dv_word o_word
);
    import qfan_pkg::*;

    logic [2:0]          w_nb;
    logic [2:0][R_W-1:0] w_r2;
    logic [2:0]          w_ge;
    t_dv_word            n_word;
    t_dv_word            r_word;
    logic                r_valid;

    for (genvar c = 0; c < 3; c++) begin : g_nb
        if (STEP >= NORM_SHIFT) begin : g_num
            assign w_nb[c] = i_word.mag[c][STEP-NORM_SHIFT];
        end else begin : g_zero
            assign w_nb[c] = 1'b0;
        end
    end

    always_comb begin
        n_word = i_word;
        for (int c = 0; c < 3; c++) begin
            w_r2[c]     = {i_word.r[c][R_W-2:0], w_nb[c]};
            w_ge[c]     = w_r2[c] >= {1'b0, i_word.m};
            n_word.r[c] = w_ge[c] ? w_r2[c] - {1'b0, i_word.m} : w_r2[c];
            n_word.q[c] = {i_word.q[c][Q_W-2:0], w_ge[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

/* verif/tb_top.sv */
// Testbench for quad_face_area_normal: drives faces on the input stream and checks
// every output word against a bit-exact predictor. Depends on qfan_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import qfan_pkg::*;

    localparam int CW       = 32;
    localparam int IN_W     = 12 * CW;
    localparam int N_RAND   = 1200;
    localparam int WD_LIMIT = 4000;
    localparam int LATENCY  = 136;

    typedef struct {
        logic signed [AREA_W-1:0] ax, ay, az;
        logic [AREA_W-1:0]        mag;
        logic signed [NORM_W-1:0] nx, ny, nz;
        logic                     degen;
    } t_face_res;

    logic                clk;
    logic                rst_n;
    logic                s_valid;
    logic                s_ready;
    logic [IN_W-1:0]     s_data;
    logic                m_valid;
    logic                m_ready;
    logic [OUT_W-1:0]    m_data;
    logic [0:0]          m_user;

    t_face_res expected_faces[$];
    int        err_count;
    int        idle_cycles;
    int        stall_left;
    bit        quiet;
    bit        no_stall;
    bit        all_sent;

    quad_face_area_normal #(.COORD_WIDTH(CW)) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic signed [AREA_W-1:0] half_cross_sat(
        logic signed [CW:0] a, logic signed [CW:0] b,
        logic signed [CW:0] c, logic signed [CW:0] d);
        logic signed [2*CW+3:0] v;
        v = (2*CW+4)'(a) * (2*CW+4)'(b) - (2*CW+4)'(c) * (2*CW+4)'(d);
        v = (v + (1 <<< COORD_FRAC_BITS)) >>> (COORD_FRAC_BITS + 1);
        if (v > (2*CW+4)'(AREA_MAX)) return AREA_MAX;
        if (v < (2*CW+4)'(AREA_MIN)) return AREA_MIN;
        return v[AREA_W-1:0];
    endfunction

    function automatic logic [AREA_W-1:0] round_root(logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] lo, hi, mid;
        lo = 0;
        hi = SUM_W'(1) << 48;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= s) lo = mid; else hi = mid;
        end
        if (s - lo * lo > lo) lo = lo + 1;
        return lo[AREA_W-1:0];
    endfunction

    function automatic logic signed [NORM_W-1:0] unit_comp(
        logic signed [AREA_W-1:0] a, logic [AREA_W-1:0] m);
        logic [AREA_W:0] mag_a;
        logic [95:0]     num, q, r;
        mag_a = a < 0 ? -(AREA_W+1)'(a) : (AREA_W+1)'(a);
        num = 96'(mag_a) << NORM_SHIFT;
        q = num / m;
        r = num % m;
        if (2 * r >= m) q = q + 1;
        if (q > (96'(1) << NORM_SHIFT)) q = 96'(1) << NORM_SHIFT;
        return a < 0 ? -NORM_W'(q) : NORM_W'(q);
    endfunction

    function automatic t_face_res predict_face(logic [IN_W-1:0] w);
        logic signed [CW-1:0] c[12];
        logic signed [CW:0]   d1x, d1y, d1z, d2x, d2y, d2z;
        logic [SUM_W-1:0]     s;
        t_face_res            f;
        for (int i = 0; i < 12; i++) c[i] = w[i*CW +: CW];
        d1x = (CW+1)'(c[3]) - (CW+1)'(c[0]);
        d1y = (CW+1)'(c[4]) - (CW+1)'(c[1]);
        d1z = (CW+1)'(c[5]) - (CW+1)'(c[2]);
        d2x = (CW+1)'(c[9]) - (CW+1)'(c[6]);
        d2y = (CW+1)'(c[10]) - (CW+1)'(c[7]);
        d2z = (CW+1)'(c[11]) - (CW+1)'(c[8]);
        f.ax = half_cross_sat(d1y, d2z, d1z, d2y);
        f.ay = half_cross_sat(d1z, d2x, d1x, d2z);
        f.az = half_cross_sat(d1x, d2y, d1y, d2x);
        s = SUM_W'(96'(f.ax) * 96'(f.ax)) + SUM_W'(96'(f.ay) * 96'(f.ay))
            + SUM_W'(96'(f.az) * 96'(f.az));
        f.mag = round_root(s);
        f.degen = (f.mag == 0);
        if (f.degen) begin
            f.nx = 0; f.ny = 0; f.nz = 0;
        end else begin
            f.nx = unit_comp(f.ax, f.mag);
            f.ny = unit_comp(f.ay, f.mag);
            f.nz = unit_comp(f.az, f.mag);
        end
        return f;
    endfunction

    task automatic report_mismatch(string what, logic [AREA_W-1:0] got,
                                   logic [AREA_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return CW'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000;
            2: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
            default: return CW'($urandom_range(0, 15)) << 16;
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_face();
        logic [IN_W-1:0] w;
        int mode;
        mode = $urandom_range(0, 3);
        for (int i = 0; i < 12; i++) w[i*CW +: CW] = rand_coord(mode);
        // occasionally collapse the second diagonal onto the first direction
        if ($urandom_range(0, 9) == 0)
            for (int i = 0; i < 6; i++) w[(6+i)*CW +: CW] = w[i*CW +: CW];
        return w;
    endfunction

    task automatic send_face(logic [IN_W-1:0] w, bit typed, t_face_res want);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        expected_faces.push_back(typed ? want : predict_face(w));
        do @(posedge clk); while (!s_ready);
    endtask

    // receiver: random stall bursts on m_ready
    always @(posedge clk) begin
        if (!rst_n || no_stall) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            m_ready    <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(1, 7);
        end
    end

    always @(posedge clk) begin
        t_face_res f;
        if (rst_n && m_valid && m_ready) begin
            if (expected_faces.size() == 0) begin
                report_mismatch("unexpected word", m_data[0 +: AREA_W], '0);
            end else begin
                f = expected_faces.pop_front();
                if (m_data[0*AREA_W +: AREA_W] !== f.ax)
                    report_mismatch("area_vec_x", m_data[0 +: AREA_W], f.ax);
                if (m_data[1*AREA_W +: AREA_W] !== f.ay)
                    report_mismatch("area_vec_y", m_data[AREA_W +: AREA_W], f.ay);
                if (m_data[2*AREA_W +: AREA_W] !== f.az)
                    report_mismatch("area_vec_z", m_data[2*AREA_W +: AREA_W], f.az);
                if (m_data[3*AREA_W +: AREA_W] !== f.mag)
                    report_mismatch("face_area", m_data[3*AREA_W +: AREA_W], f.mag);
                if (m_data[4*AREA_W +: NORM_W] !== f.nx)
                    report_mismatch("normal_x", m_data[4*AREA_W +: NORM_W], f.nx);
                if (m_data[4*AREA_W+NORM_W +: NORM_W] !== f.ny)
                    report_mismatch("normal_y", m_data[4*AREA_W+NORM_W +: NORM_W], f.ny);
                if (m_data[4*AREA_W+2*NORM_W +: NORM_W] !== f.nz)
                    report_mismatch("normal_z", m_data[4*AREA_W+2*NORM_W +: NORM_W], f.nz);
                if (m_user[0] !== f.degen)
                    report_mismatch("degenerate", m_user, f.degen);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)
            || (all_sent && expected_faces.size() == 0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    localparam logic [CW-1:0] MAXC = 32'h7fff_ffff;
    localparam logic [CW-1:0] MINC = 32'h8000_0000;
    localparam logic [CW-1:0] ONE  = 32'h0001_0000;

    logic [IN_W-1:0] dir_faces[$];
    bit              dir_typed[$];
    t_face_res       dir_want[$];

    function automatic logic [IN_W-1:0] face_of(logic [CW-1:0] c[12]);
        logic [IN_W-1:0] w;
        for (int i = 0; i < 12; i++) w[i*CW +: CW] = c[i];
        return w;
    endfunction

    task automatic add_row(logic [CW-1:0] c[12], bit typed, t_face_res want);
        dir_faces.push_back(face_of(c));
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    initial begin
        logic [CW-1:0] c[12];
        t_face_res     none;
        t_face_res     want;
        rst_n = 1'b0; s_valid = 1'b0; s_data = '0;
        quiet = 0; no_stall = 0; all_sent = 0;
        none = '{default: 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: all zero, unit square, extremes, degenerate, saturation
        want = none; want.degen = 1'b1;
        c = '{default: 0};                                   add_row(c, 1'b1, want);
        want = none; want.az = 48'h1_0000; want.mag = 48'h1_0000; want.nz = 32'h4000_0000;
        c = '{0, 0, 0, ONE, ONE, 0, ONE, 0, 0, 0, ONE, 0};   add_row(c, 1'b1, want);
        c = '{0, 0, 0, ONE, 0, 0, 0, 0, 0, 2*ONE, 0, 0};     add_row(c, 1'b0, none);
        c = '{MINC, MINC, MINC, MAXC, MAXC, MAXC,
              MAXC, MINC, MINC, MINC, MAXC, MAXC};           add_row(c, 1'b0, none);
        c = '{MINC, 0, 0, MAXC, 0, 0, 0, MINC, 0, 0, MAXC, 0}; add_row(c, 1'b0, none);
        c = '{MAXC, 0, 0, MINC, 0, 0, 0, MINC, 0, 0, MAXC, 0}; add_row(c, 1'b0, none);
        c = '{0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0};           add_row(c, 1'b0, none);
        c = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0};           add_row(c, 1'b0, none);
        c = '{0, 0, 0, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 1, 0}; add_row(c, 1'b0, none);
        c = '{0, 0, 0, 3, 0, 0, 0, 0, 0, 0, 1, 0};           add_row(c, 1'b0, none);
        c = '{0, 0, 0, ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0};   add_row(c, 1'b0, none);
        c = '{default: MAXC};                                add_row(c, 1'b0, none);
        c = '{default: MINC};                                add_row(c, 1'b0, none);
        c = '{default: 32'hffff_ffff};                       add_row(c, 1'b0, none);
        c = '{0, 0, 0, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678,
              32'haaaa_aaaa, 32'h5555_5555, 32'hedcb_a987, 0, 0, 0};
        add_row(c, 1'b0, none);

        // the first rows have results readable at a glance
        foreach (dir_faces[i]) send_face(dir_faces[i], dir_typed[i], dir_want[i]);
        for (int n = 0; n < N_RAND; n++) begin
            if (n == N_RAND - 150) begin
                quiet = 1;
                no_stall = 1;
            end
            send_face(rand_face(), 1'b0, none);
        end
        s_valid <= 1'b0;
        all_sent = 1;
        while (expected_faces.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
